// File: src/sha512_pkg.sv
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } seq_state_e;

  localparam int unsigned Rounds = 80;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] KTab [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// File: src/sha512_round.sv
module sha512_round
  import sha512_pkg::*;
(
  input  logic [63:0] vars_i [8],
  input  logic [63:0] w_i,
  input  logic [63:0] k_i,
  output logic [63:0] vars_o [8]
);
  logic [63:0] t1, t2, a, b, c, e, f, g;

  always_comb begin
    a = vars_i[0];
    b = vars_i[1];
    c = vars_i[2];
    e = vars_i[4];
    f = vars_i[5];
    g = vars_i[6];
    t1 = vars_i[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
       + ((e & f) ^ (~e & g)) + k_i + w_i;
    t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
    vars_o[7] = g;
    vars_o[6] = f;
    vars_o[5] = e;
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = c;
    vars_o[2] = b;
    vars_o[1] = a;
    vars_o[0] = t1 + t2;
  end
endmodule

// File: src/sha512_sched.sv
module sha512_sched
  import sha512_pkg::*;
(
  input  logic [63:0] win_i [16],
  input  logic [6:0]  round_i,
  output logic [63:0] w_o
);
  logic [3:0]  t;
  logic [63:0] x2, x15, s0, s1;

  // The window is kept in place: slot t&15 holds W[t-16] until rewritten.
  always_comb begin
    t   = round_i[3:0];
    x2  = win_i[t - 4'd2];
    x15 = win_i[t - 4'd15];
    s1  = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
    s0  = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
    if (round_i < 7'd16) begin
      w_o = win_i[t];
    end else begin
      w_o = s1 + win_i[t - 4'd7] + s0 + win_i[t];
    end
  end
endmodule

// File: src/sha512_stream_hasher.sv
// SHA-512 stream hasher.
// Input channel: in_valid_i / in_stall_o carry one in_item_t per transfer, a
// 64-bit big-endian message word with its valid byte count and a last flag.
// Output channel: out_valid_o / out_stall_i carry the eight digest words of a
// message, index 0 first, digest_last set on index 7.
// A word that does not complete a 128-byte block is stored in the window. A word that
// completes a block is stored, then runs 80 rounds of the shared round unit
// (one round per cycle), and then the result is folded into the chaining
// value. The last word adds one or two padding blocks, whose remaining slots
// are written with padding and then compressed, then eight output transfers, one
// per cycle when the receiver does not stall. The single round unit sets the
// sustained rate, as no new word is taken while a block is compressed.
// The input is stalled for the whole of padding, compression and digest
// output. While the receiver stalls, the current digest word is held steady.
// Reset loads the initial hash value and clears the byte count and position;
// the block is ready for a new message straight after reset.
module sha512_stream_hasher
  import sha512_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  seq_state_e  state_q, state_d;
  logic [63:0] chain_q [8];
  logic [63:0] vars_q [8];
  logic [63:0] vars_nx [8];
  logic [63:0] win_q [16];
  logic [63:0] w_sched;
  logic [3:0]  pos_q;
  logic [60:0] bytes_q;
  logic [6:0]  round_q;
  logic [2:0]  emit_q;
  logic        final_q;   // compression belongs to the padding of a last word
  logic        pad2_q;    // length still to go: padding spans into next block
  // A full last word landing in slot 15 owes the 0x80 marker at slot 0 of the
  // next block; the first padding write supplies it.
  logic        marker_owed_q;
  logic [63:0] pad_word;
  logic        accept;
  logic        blk_full;  // the accepted transfer fills the window
  logic [3:0]  nb;
  logic [63:0] keep, last_val;

  sha512_sched u_sched (.win_i(win_q), .round_i(round_q), .w_o(w_sched));
  sha512_round u_round (.vars_i(vars_q), .w_i(w_sched), .k_i(KTab[round_q]),
                        .vars_o(vars_nx));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_data_o.digest_word  = chain_q[emit_q];
  assign out_data_o.digest_index = emit_q;
  assign out_data_o.digest_last  = (emit_q == 3'd7);

  always_comb begin
    nb = (in_data_i.valid_bytes > 4'd8) ? 4'd8 : in_data_i.valid_bytes;
    keep = (nb == 4'd0) ? 64'd0 : ~(64'hFFFFFFFFFFFFFFFF >> {nb, 3'b000});
    last_val = (in_data_i.message_word & keep) | ((64'h80 << 56) >> {nb, 3'b000});
    if (nb == 4'd8) begin
      last_val = in_data_i.message_word;
    end
    // A full last word in slot 14 also fills slot 15 with the marker.
    blk_full = accept && (pos_q == 4'd15 ||
                          (in_data_i.last_word && nb == 4'd8 && pos_q == 4'd14));
    // Padding slot contents: the owed marker, zeros, and the length word at
    // slot 15 once final.
    pad_word = 64'd0;
    if (marker_owed_q) begin
      pad_word = 64'h80 << 56;
    end else if (pos_q == 4'd15 && !pad2_q) begin
      pad_word = {bytes_q, 3'b000};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (blk_full) begin
            state_d = ST_ROUND;
          end else if (in_data_i.last_word) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: if (round_q == 7'(Rounds - 1)) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!final_q) state_d = ST_IDLE;
        else if (pad2_q || pos_q != 4'd0) state_d = ST_PAD;
        else state_d = ST_EMIT;
      end
      ST_PAD: if (pos_q == 4'd15) state_d = ST_ROUND;
      ST_EMIT: if (!out_stall_i && emit_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= IV[i];
        vars_q[i]  <= 64'd0;
      end
      for (int i = 0; i < 16; i++) begin
        win_q[i] <= 64'd0;
      end
      pos_q         <= 4'd0;
      bytes_q       <= 61'd0;
      round_q       <= 7'd0;
      emit_q        <= 3'd0;
      final_q       <= 1'b0;
      pad2_q        <= 1'b0;
      marker_owed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_data_i.last_word && nb == 4'd8) begin
              // Full last word: the 0x80 marker goes into the next slot.
              win_q[pos_q] <= in_data_i.message_word;
              bytes_q <= bytes_q + 61'd8;
              final_q <= 1'b1;
              if (pos_q == 4'd15) begin
                pad2_q        <= 1'b1;   // marker word still owed
                marker_owed_q <= 1'b1;
                pos_q         <= 4'd0;
              end else begin
                win_q[pos_q + 4'd1] <= 64'h80 << 56;
                pad2_q <= (pos_q >= 4'd13);
                pos_q  <= pos_q + 4'd2;
              end
            end else if (in_data_i.last_word) begin
              win_q[pos_q] <= last_val;
              bytes_q <= bytes_q + 61'(nb);
              final_q <= 1'b1;
              pad2_q  <= (pos_q >= 4'd14);
              pos_q   <= pos_q + 4'd1;
            end else begin
              win_q[pos_q] <= in_data_i.message_word;
              bytes_q <= bytes_q + 61'd8;
              final_q <= 1'b0;
              pos_q   <= pos_q + 4'd1;
            end
            if (blk_full) begin
              for (int i = 0; i < 8; i++) vars_q[i] <= chain_q[i];
            end
          end
        end
        ST_PAD: begin
          win_q[pos_q]  <= pad_word;
          marker_owed_q <= 1'b0;
          pos_q <= pos_q + 4'd1;
          if (pos_q == 4'd15) begin
            for (int i = 0; i < 8; i++) vars_q[i] <= chain_q[i];
          end
        end
        ST_ROUND: begin
          vars_q  <= vars_nx;
          if (round_q >= 7'd16) win_q[round_q[3:0]] <= w_sched;
          round_q <= (round_q == 7'(Rounds - 1)) ? 7'd0 : round_q + 7'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars_q[i];
          if (final_q && pad2_q) begin
            pad2_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            emit_q <= emit_q + 3'd1;
            if (emit_q == 3'd7) begin
              for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
              bytes_q <= 61'd0;
              pos_q   <= 4'd0;
              final_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
